/* hdl/stsum_pkg.sv */
package stsum_pkg;

   localparam int MAX_ELEMENTS_DEF = 1024;

   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int SIZE_W  = 11;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic {
      STATUS_DONE   = 1'b0,
      STATUS_IGNORE = 1'b1
   } status_code_type;

   typedef struct packed {
      logic                       op;
      logic [INDEX_W-1:0]         index;
      logic signed [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]         range_low;
      logic [INDEX_W-1:0]         range_high;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  sum;
      logic                       status;
   } rsp_payload_type;

   typedef logic [SIZE_W-1:0] csr_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic clr_start;
      logic clr_step;
      logic load;
      logic desc_step;
      logic leaf_write;
      logic sib_read;
      logic up_write;
      logic pop;
      logic node_read;
      logic acc_add;
      logic split;
      logic rsp_load;
   } stsum_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic is_query;
      logic oob;
      logic at_leaf;
      logic at_root;
      logic up_last;
      logic stack_empty;
      logic disjoint;
      logic covered;
      logic rsp_free;
   } stsum_status_type;

endpackage

/* hdl/stsum_chan_if.sv */
interface stsum_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/stsum_ctrl.sv */
module stsum_ctrl
   import stsum_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_fire,
   input  logic             csr_fire,
   input  stsum_status_type status,
   output logic             req_ready,
   output stsum_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_DESCEND,
      S_SIB_RD,
      S_UP_WR,
      S_Q_POP,
      S_Q_EVAL,
      S_Q_ACC,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.is_query) state_in = S_Q_POP;
            else if (status.oob) state_in = S_DONE;
            else state_in = S_DESCEND;
         end
         S_DESCEND: begin
            if (status.at_leaf) begin
               cmd.leaf_write = 1'b1;
               state_in = status.at_root ? S_DONE : S_SIB_RD;
            end else begin
               cmd.desc_step = 1'b1;
            end
         end
         S_SIB_RD: begin
            cmd.sib_read = 1'b1;
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            cmd.up_write = 1'b1;
            state_in = status.up_last ? S_DONE : S_SIB_RD;
         end
         S_Q_POP: begin
            if (status.stack_empty) begin
               state_in = S_DONE;
            end else begin
               cmd.pop = 1'b1;
               state_in = S_Q_EVAL;
            end
         end
         S_Q_EVAL: begin
            priority if (status.disjoint) begin
               state_in = S_Q_POP;
            end else if (status.covered) begin
               cmd.node_read = 1'b1;
               state_in = S_Q_ACC;
            end else begin
               cmd.split = 1'b1;
               state_in = S_Q_POP;
            end
         end
         S_Q_ACC: begin
            cmd.acc_add = 1'b1;
            state_in = S_Q_POP;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
      // a size write restarts the clearing pass and holds off requests
      if (csr_fire) begin
         cmd           = '0;
         cmd.clr_start = 1'b1;
         req_ready     = 1'b0;
         state_in      = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/stsum_dp.sv */
module stsum_dp
   import stsum_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  stsum_cmd_type    cmd,
   input  req_payload_type  req_data,
   input  logic             csr_fire,
   input  csr_payload_type  csr_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output rsp_payload_type  rsp_data,
   output stsum_status_type status
);

   localparam int NODES = 4 * MAX_ELEMENTS;
   localparam int AW    = $clog2(NODES);
   localparam int EW    = $clog2(MAX_ELEMENTS);
   localparam int CW    = (EW > INDEX_W) ? EW : INDEX_W;
   localparam int SW    = $clog2(MAX_ELEMENTS + 1);
   localparam int ZW    = (SW > SIZE_W) ? SW : SIZE_W;
   localparam int LEVELS = EW + 2;
   localparam int IW    = $clog2(LEVELS);
   localparam int SD    = 2 ** IW;

   logic [VALUE_W-1:0] mem [NODES];
   logic [VALUE_W-1:0] rdata_ff;

   logic [SW-1:0]      size_ff;
   logic [AW-1:0]      clr_cnt_ff;
   req_payload_type    item_ff;
   logic               oob_ff;
   logic [AW-1:0]      k_ff;
   logic [EW-1:0]      lo_ff, hi_ff;
   logic [VALUE_W-1:0] cur_ff, acc_ff;
   logic [AW-1:0]      stk_k_ff  [SD];
   logic [EW-1:0]      stk_lo_ff [SD];
   logic [EW-1:0]      stk_hi_ff [SD];
   logic [IW:0]        sp_ff;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic [ZW-1:0]      csr_wide;
   logic [SW-1:0]      size_in;
   logic [EW-1:0]      last;
   logic [EW:0]        mid_sum;
   logic [EW-1:0]      mid;
   logic [AW-1:0]      left_k, right_k, parent_k, sib_k;
   logic [IW:0]        sp_dec, sp_inc;
   logic [CW-1:0]      q_lo, q_hi, c_lo, c_hi;
   logic [VALUE_W-1:0] up_sum;
   logic               we;
   logic [AW-1:0]      addr;
   logic [VALUE_W-1:0] wdata;

   always_comb begin
      csr_wide = ZW'(csr_data);
      priority if (csr_wide == '0) size_in = SW'(1);
      else if (csr_wide > ZW'(MAX_ELEMENTS)) size_in = SW'(MAX_ELEMENTS);
      else size_in = SW'(csr_wide);
   end

   assign last     = EW'(size_ff - SW'(1));
   assign mid_sum  = (EW+1)'(lo_ff) + (EW+1)'(hi_ff);
   assign mid      = mid_sum[EW:1];
   assign left_k   = (k_ff << 1) + AW'(1);
   assign right_k  = (k_ff << 1) + AW'(2);
   assign parent_k = (k_ff - AW'(1)) >> 1;
   assign sib_k    = k_ff[0] ? (k_ff + AW'(1)) : (k_ff - AW'(1));
   assign sp_dec   = sp_ff - (IW+1)'(1);
   assign sp_inc   = sp_ff + (IW+1)'(1);
   assign q_lo     = CW'(item_ff.range_low);
   assign q_hi     = CW'(item_ff.range_high);
   assign c_lo     = CW'(lo_ff);
   assign c_hi     = CW'(hi_ff);
   assign up_sum   = cur_ff + rdata_ff;

   always_comb begin
      we    = 1'b0;
      addr  = k_ff;
      wdata = '0;
      priority if (cmd.clr_step) begin
         we   = 1'b1;
         addr = clr_cnt_ff;
      end else if (cmd.leaf_write) begin
         we    = 1'b1;
         wdata = item_ff.value;
      end else if (cmd.up_write) begin
         we    = 1'b1;
         addr  = parent_k;
         wdata = up_sum;
      end else if (cmd.sib_read) begin
         addr = sib_k;
      end else if (cmd.node_read) begin
         addr = k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SW'(MAX_ELEMENTS);
         clr_cnt_ff   <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) size_ff <= size_in;
         if (cmd.clr_start) clr_cnt_ff <= '0;
         else if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (cmd.load) begin
            sp_ff <= (req_data.op == OP_QUERY) ? (IW+1)'(1) : '0;
         end else if (cmd.pop) begin
            sp_ff <= sp_dec;
         end else if (cmd.split) begin
            sp_ff <= sp_ff + (IW+1)'(2);
         end
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff      <= req_data;
         oob_ff       <= ZW'(req_data.index) >= ZW'(size_ff);
         k_ff         <= '0;
         lo_ff        <= '0;
         hi_ff        <= last;
         acc_ff       <= '0;
         stk_k_ff[0]  <= '0;
         stk_lo_ff[0] <= '0;
         stk_hi_ff[0] <= last;
      end
      if (cmd.desc_step) begin
         if (CW'(item_ff.index) <= CW'(mid)) begin
            k_ff  <= left_k;
            hi_ff <= mid;
         end else begin
            k_ff  <= right_k;
            lo_ff <= mid + EW'(1);
         end
      end
      if (cmd.leaf_write) cur_ff <= item_ff.value;
      if (cmd.up_write) begin
         cur_ff <= up_sum;
         k_ff   <= parent_k;
      end
      if (cmd.pop) begin
         k_ff  <= stk_k_ff[sp_dec[IW-1:0]];
         lo_ff <= stk_lo_ff[sp_dec[IW-1:0]];
         hi_ff <= stk_hi_ff[sp_dec[IW-1:0]];
      end
      if (cmd.split) begin
         stk_k_ff[sp_ff[IW-1:0]]   <= right_k;
         stk_lo_ff[sp_ff[IW-1:0]]  <= mid + EW'(1);
         stk_hi_ff[sp_ff[IW-1:0]]  <= hi_ff;
         stk_k_ff[sp_inc[IW-1:0]]  <= left_k;
         stk_lo_ff[sp_inc[IW-1:0]] <= lo_ff;
         stk_hi_ff[sp_inc[IW-1:0]] <= mid;
      end
      if (cmd.acc_add) acc_ff <= acc_ff + rdata_ff;
      if (cmd.rsp_load) begin
         rsp_ff.sum    <= (item_ff.op == OP_QUERY) ? acc_ff : '0;
         rsp_ff.status <= (item_ff.op == OP_UPDATE && oob_ff) ? STATUS_IGNORE : STATUS_DONE;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      status.clr_done    = clr_cnt_ff == AW'(NODES - 1);
      status.is_query    = item_ff.op == OP_QUERY;
      status.oob         = oob_ff;
      status.at_leaf     = lo_ff >= hi_ff;
      status.at_root     = k_ff == '0;
      status.up_last     = k_ff <= AW'(2);
      status.stack_empty = sp_ff == '0;
      status.disjoint    = (q_hi < c_lo) || (c_hi < q_lo);
      status.covered     = (q_lo <= c_lo) && (c_hi <= q_hi);
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

/* hdl/segment_tree_range_sum.sv */
// Range-sum segment tree over up to MAX_ELEMENTS signed 32-bit elements, one
// request transaction at a time: an update walks down to its leaf level by
// level and back up with a sibling read and a parent write per level, and an
// out-of-range update is ignored; a query pops a node stack, skipping
// disjoint nodes, adding covered ones and splitting the rest. Both are
// bounded by the single-port node memory. After reset and after every
// size_in_use write the node memory is swept to zero, during which no
// request is taken. A finished response waits in an output register while
// the next request runs.
module segment_tree_range_sum
   import stsum_pkg::*;
#(
   parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   stsum_chan_if.sink   req_if,
   stsum_chan_if.source rsp_if,
   stsum_chan_if.sink   csr_if
);

   stsum_cmd_type    cmd;
   stsum_status_type status;
   logic             req_fire, csr_fire, req_ready;
   rsp_payload_type  rsp_data;

   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;
   assign req_if.ready = req_ready;
   assign req_fire     = req_if.valid && req_ready;
   assign rsp_if.data  = rsp_data;

   stsum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .csr_fire  (csr_fire),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   stsum_dp #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_if.data),
      .csr_fire  (csr_fire),
      .csr_data  (csr_if.data),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_data),
      .status    (status)
   );

`ifndef SYNTH
   ap_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while one is in flight");

   ap_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_if.valid && csr_if.ready) |=> !req_if.ready)
      else $error("request taken during clearing pass");

   ap_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.status) |-> (rsp_if.data.sum == '0))
      else $error("ignored update carries nonzero sum");
`endif

endmodule
